/* rtl/mtep_pkg.sv */
// package for the midi track event parser: types, codes and constants
`timescale 1ns / 1ps

package mtep_pkg;

  localparam int VLQ_MAX_BYTES_DEF = 4;
  localparam int TICK_BITS_DEF     = 32;

  localparam int RES_SLOTS = 3;

  // result kinds
  localparam logic [2:0] KIND_CHAN    = 3'd0;
  localparam logic [2:0] KIND_META    = 3'd1;
  localparam logic [2:0] KIND_SYSEX   = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_TRUNC   = 3'd4;
  localparam logic [2:0] KIND_ERROR   = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NO_RS    = 2'd1;
  localparam logic [1:0] ERR_UNEXP    = 2'd2;
  localparam logic [1:0] ERR_BAD_DATA = 2'd3;

  // status bytes and message types
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_ESCAPE    = 8'hF7;
  localparam logic [7:0] ST_SYS_FIRST = 8'hF1;
  localparam logic [7:0] ST_SYS_BASE  = 8'hF0;
  localparam logic [7:0] META_EOT     = 8'h2F;
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] TYPE_PROGRAM  = 4'hC;
  localparam logic [3:0] TYPE_CH_PRESS = 4'hD;
  localparam logic [6:0] REL_VELOCITY  = 7'h40;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_DATA,
    PH_META_TYPE,
    PH_LEN,
    PH_PAYLOAD
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       track_first;
    logic       track_last;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tick;
    logic [7:0]  status;
    logic [7:0]  meta_type;
    logic [6:0]  data_first;
    logic [6:0]  data_second;
    logic [28:0] payload_length;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        run_last;
  } res_t;

  typedef struct packed {
    logic [1:0]                count;
    res_t [RES_SLOTS-1:0]      item;
  } res_grp_t;

endpackage

/* rtl/mtep_parser.sv */
// track byte parser: parser state registers and per-byte result decode
`timescale 1ns / 1ps

module mtep_parser #(
  parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF,
  parameter int TICK_BITS     = mtep_pkg::TICK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  mtep_pkg::in_item_t item,
  input  logic               short_note_off,
  output mtep_pkg::res_grp_t grp
);

  import mtep_pkg::*;

  localparam int CW = $clog2(VLQ_MAX_BYTES + 1);

  phase_t               phase_r, phase_nxt, e_phase, phase_c;
  logic [TICK_BITS-1:0] tick_r, tick_nxt, e_tick, tick_c;
  logic [7:0]           rs_r, rs_nxt, e_rs;
  logic [27:0]          acc_r, acc_nxt, e_acc;
  logic [CW-1:0]        cnt_r, cnt_nxt, e_cnt, cnt_c;
  logic [7:0]           cur_r, cur_nxt, e_cur;
  logic [7:0]           meta_r, meta_nxt, e_meta;
  logic [6:0]           held_r, held_nxt, e_held;
  logic                 di_r, di_nxt, e_di;
  logic [27:0]          left_r, left_nxt, e_left;
  logic                 done_r, done_nxt, e_done, done_c;

  logic [7:0]    b;
  logic          active;
  logic [27:0]   acc_t;
  logic [CW-1:0] cnt_t;
  logic          vlq_end, vlq_over;
  logic          sys_err;
  logic          data_go;
  logic [7:0]    ds;
  logic          di;
  logic          shortoff, one_byte;
  logic          data_emit;
  logic          eot;
  logic          f0;
  logic [27:0]   left_dec;
  logic [31:0]   tick_out;
  logic          trunc;
  logic [1:0]    np;
  res_t          p0, p1;

  function automatic res_t mk(input logic [2:0] k, input logic [31:0] t,
                              input logic [7:0] st, input logic [7:0] mt,
                              input logic [6:0] d0, input logic [6:0] d1,
                              input logic [28:0] pl, input logic [7:0] pb,
                              input logic [1:0] ec);
    res_t r;
    r.kind           = k;
    r.tick           = t;
    r.status         = st;
    r.meta_type      = mt;
    r.data_first     = d0;
    r.data_second    = d1;
    r.payload_length = pl;
    r.payload_byte   = pb;
    r.error_code     = ec;
    r.run_last       = 1'b0;
    return r;
  endfunction

  // first byte of a track starts from reset values
  always_comb begin
    if (item.track_first) begin
      e_phase = PH_DELTA;
      e_tick  = '0;
      e_rs    = '0;
      e_acc   = '0;
      e_cnt   = '0;
      e_cur   = '0;
      e_meta  = '0;
      e_held  = '0;
      e_di    = 1'b0;
      e_left  = '0;
      e_done  = 1'b0;
    end else begin
      e_phase = phase_r;
      e_tick  = tick_r;
      e_rs    = rs_r;
      e_acc   = acc_r;
      e_cnt   = cnt_r;
      e_cur   = cur_r;
      e_meta  = meta_r;
      e_held  = held_r;
      e_di    = di_r;
      e_left  = left_r;
      e_done  = done_r;
    end
  end

  assign b        = item.byte_value;
  assign active   = !e_done;
  assign acc_t    = {e_acc[20:0], b[6:0]};
  assign cnt_t    = e_cnt + CW'(1);
  assign vlq_end  = !b[7];
  assign vlq_over = b[7] && (cnt_t >= CW'(VLQ_MAX_BYTES));
  assign sys_err  = (b >= ST_SYS_FIRST) && (b != ST_ESCAPE) && (b != ST_META);
  assign data_go  = ((e_phase == PH_STATUS) && !b[7] && (e_rs != '0)) ||
                    (e_phase == PH_DATA);
  assign ds       = (e_phase == PH_STATUS) ? e_rs : e_cur;
  assign di       = (e_phase == PH_STATUS) ? 1'b0 : e_di;
  assign shortoff = (ds[7:4] == TYPE_NOTE_OFF) && short_note_off;
  assign one_byte = (ds[7:4] == TYPE_PROGRAM) || (ds[7:4] == TYPE_CH_PRESS) || shortoff;
  assign data_emit = !b[7] && (di || one_byte);
  assign eot      = (e_cur == ST_META) && (e_meta == META_EOT);
  assign f0       = (e_cur == ST_SYSEX);
  assign left_dec = e_left - 28'd1;

  // next state
  always_comb begin
    phase_c  = e_phase;
    tick_c   = e_tick;
    rs_nxt   = e_rs;
    acc_nxt  = e_acc;
    cnt_c    = e_cnt;
    cur_nxt  = e_cur;
    meta_nxt = e_meta;
    held_nxt = e_held;
    di_nxt   = e_di;
    left_nxt = e_left;
    done_c   = e_done;
    if (active) begin
      unique case (e_phase)
        PH_DELTA: begin
          acc_nxt = acc_t;
          cnt_c   = cnt_t;
          if (vlq_end) begin
            tick_c  = e_tick + TICK_BITS'(acc_t);
            acc_nxt = '0;
            cnt_c   = '0;
            phase_c = PH_STATUS;
          end else if (vlq_over) begin
            done_c = 1'b1;
          end
        end
        PH_STATUS: begin
          meta_nxt = '0;
          di_nxt   = 1'b0;
          if (b[7]) begin
            cur_nxt = b;
            if (b < ST_SYS_BASE) begin
              rs_nxt = b;
            end
            if (b == ST_META) begin
              phase_c = PH_META_TYPE;
            end else if ((b == ST_SYSEX) || (b == ST_ESCAPE)) begin
              acc_nxt = '0;
              cnt_c   = '0;
              phase_c = PH_LEN;
            end else if (sys_err) begin
              done_c = 1'b1;
            end else begin
              phase_c = PH_DATA;
            end
          end else if (e_rs == '0) begin
            done_c = 1'b1;
          end else begin
            cur_nxt = e_rs;
          end
        end
        PH_DATA: begin
        end
        PH_META_TYPE: begin
          meta_nxt = b;
          acc_nxt  = '0;
          cnt_c    = '0;
          phase_c  = PH_LEN;
        end
        PH_LEN: begin
          acc_nxt = acc_t;
          cnt_c   = cnt_t;
          if (vlq_end) begin
            left_nxt = acc_t;
            if (acc_t == '0) begin
              phase_c = PH_DELTA;
              acc_nxt = '0;
              cnt_c   = '0;
              if (eot) begin
                done_c = 1'b1;
              end
            end else begin
              phase_c = PH_PAYLOAD;
            end
          end else if (vlq_over) begin
            done_c = 1'b1;
          end
        end
        default: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_c = PH_DELTA;
            acc_nxt = '0;
            cnt_c   = '0;
            if (eot) begin
              done_c = 1'b1;
            end
          end
        end
      endcase
      if (data_go) begin
        if (b[7]) begin
          done_c = 1'b1;
        end else if (!di) begin
          held_nxt = b[6:0];
          di_nxt   = 1'b1;
          if (one_byte) begin
            phase_c = PH_DELTA;
            acc_nxt = '0;
            cnt_c   = '0;
          end else begin
            phase_c = PH_DATA;
          end
        end else begin
          di_nxt  = 1'b0;
          phase_c = PH_DELTA;
          acc_nxt = '0;
          cnt_c   = '0;
        end
      end
    end
  end

  assign trunc     = active && item.track_last && !done_c &&
                     ((phase_c != PH_DELTA) || (cnt_c != '0));
  assign phase_nxt = phase_c;
  assign tick_nxt  = tick_c;
  assign cnt_nxt   = cnt_c;
  assign done_nxt  = done_c || (active && item.track_last);
  assign tick_out  = 32'(tick_c);

  // results of this byte
  always_comb begin
    np = 2'd0;
    p0 = '0;
    p1 = '0;
    if (active) begin
      unique case (e_phase)
        PH_DELTA: begin
          if (vlq_end) begin
            np = 2'd0;
          end else if (vlq_over) begin
            p0 = mk(KIND_TRUNC, tick_out, '0, '0, '0, '0, '0, '0, ERR_NONE);
            np = 2'd1;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            if (sys_err) begin
              p0 = mk(KIND_ERROR, tick_out, '0, '0, '0, '0, '0, '0, ERR_UNEXP);
              np = 2'd1;
            end
          end else if (e_rs == '0) begin
            p0 = mk(KIND_ERROR, tick_out, '0, '0, '0, '0, '0, '0, ERR_NO_RS);
            np = 2'd1;
          end
        end
        PH_DATA: begin
          if (b[7]) begin
            p0 = mk(KIND_ERROR, tick_out, '0, '0, '0, '0, '0, '0, ERR_BAD_DATA);
            np = 2'd1;
          end
        end
        PH_META_TYPE: begin
          np = 2'd0;
        end
        PH_LEN: begin
          if (vlq_end) begin
            p0 = mk((e_cur == ST_META) ? KIND_META : KIND_SYSEX, tick_out, e_cur,
                    e_meta, '0, '0, {1'b0, acc_t} + 29'(f0), '0, ERR_NONE);
            np = 2'd1;
            if (f0) begin
              p1 = mk(KIND_PAYLOAD, tick_out, e_cur, '0, '0, '0, '0, ST_SYSEX,
                      ERR_NONE);
              np = 2'd2;
            end
          end else if (vlq_over) begin
            p0 = mk(KIND_TRUNC, tick_out, '0, '0, '0, '0, '0, '0, ERR_NONE);
            np = 2'd1;
          end
        end
        default: begin
          p0 = mk(KIND_PAYLOAD, tick_out, e_cur, e_meta, '0, '0, '0, b, ERR_NONE);
          np = 2'd1;
        end
      endcase
      if (data_go && data_emit) begin
        p0 = mk(KIND_CHAN, tick_out, ds, '0, di ? e_held : b[6:0],
                di ? b[6:0] : (shortoff ? REL_VELOCITY : 7'd0), '0, '0, ERR_NONE);
        np = 2'd1;
      end
    end
  end

  always_comb begin
    grp.item    = '0;
    grp.item[0] = p0;
    grp.item[1] = p1;
    if (trunc) begin
      grp.item[np] = mk(KIND_TRUNC, tick_out, '0, '0, '0, '0, '0, '0, ERR_NONE);
    end
    grp.count = np + 2'(trunc);
    if (grp.count != 2'd0) begin
      grp.item[grp.count - 2'd1].run_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DELTA;
      tick_r  <= '0;
      rs_r    <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
      cur_r   <= '0;
      meta_r  <= '0;
      held_r  <= '0;
      di_r    <= 1'b0;
      left_r  <= '0;
      done_r  <= 1'b0;
    end else if (take) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      rs_r    <= rs_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      meta_r  <= meta_nxt;
      held_r  <= held_nxt;
      di_r    <= di_nxt;
      left_r  <= left_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

/* rtl/midi_track_event_parser_top.sv */
// top level of the midi track event parser: input register, result group, config
//
// channel  dir  tdata                           tuser        tlast
// in_      in   byte_value                      track_first  track_last
// out_     out  tick .. error_code (see port)   kind         run_last
// cfg_     in   short_note_off (cfg_wdata)      -            -
//
// one byte per cycle when each byte gives at most one result and out_ is ready;
// a byte with n results holds the group for n out transactions, one result each
// the input register takes a byte while the result group still drains
// synchronous active-low reset clears parser state, tick and running status
// a stall on out_ fills the input register, then drops in_tready
`timescale 1ns / 1ps

module midi_track_event_parser_top #(
  parameter int VLQ_MAX_BYTES = mtep_pkg::VLQ_MAX_BYTES_DEF,
  parameter int TICK_BITS     = mtep_pkg::TICK_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // byte_value
  input  logic         in_tuser,   // track_first
  input  logic         in_tlast,   // track_last
  output logic         out_tvalid,
  input  logic         out_tready,
  // tick, status, meta_type, data_first, data_second, payload_length,
  // payload_byte, error_code, zero fill
  output logic [103:0] out_tdata,
  output logic [2:0]   out_tuser,  // kind
  output logic         out_tlast,  // run_last
  input  logic         cfg_we,
  input  logic [0:0]   cfg_wdata   // short_note_off
);

  import mtep_pkg::*;

  logic                   sno_r;
  logic                   in_v_r;
  in_item_t               in_item_r;
  res_t [RES_SLOTS-1:0]   grp_item_r;
  logic [1:0]             grp_cnt_r;
  res_grp_t               grp;
  logic                   grp_free;
  logic                   take;
  logic                   pop;
  res_t                   head;

  assign pop       = out_tvalid && out_tready;
  assign grp_free  = (grp_cnt_r == 2'd0) || ((grp_cnt_r == 2'd1) && out_tready);
  assign take      = in_v_r && grp_free;
  assign in_tready = !in_v_r || take;

  mtep_parser #(
    .VLQ_MAX_BYTES(VLQ_MAX_BYTES),
    .TICK_BITS    (TICK_BITS)
  ) u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (take),
    .item          (in_item_r),
    .short_note_off(sno_r),
    .grp           (grp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sno_r <= 1'b0;
    end else if (cfg_we) begin
      sno_r <= cfg_wdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (take) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.byte_value  <= in_tdata;
      in_item_r.track_first <= in_tuser;
      in_item_r.track_last  <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r <= 2'd0;
    end else if (take) begin
      grp_cnt_r <= grp.count;
    end else if (pop) begin
      grp_cnt_r <= grp_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      grp_item_r <= grp.item;
    end else if (pop) begin
      grp_item_r <= {res_t'('0), grp_item_r[RES_SLOTS-1:1]};
    end
  end

  assign head       = grp_item_r[0];
  assign out_tvalid = (grp_cnt_r != 2'd0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.run_last;
  assign out_tdata  = {3'b000, head.error_code, head.payload_byte, head.payload_length,
                       head.data_second, head.data_first, head.meta_type, head.status,
                       head.tick};

`ifndef SYNTHESIS
  a_take_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (grp_cnt_r == 2'd0) || (grp_cnt_r == 2'd1))
    else $error("byte taken while result group busy");

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (grp_cnt_r == 2'd1)))
    else $error("run_last not on final result of a byte");

  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !take && (grp_cnt_r > 2'd1)) |=> (grp_item_r[0] == $past(grp_item_r[1])))
    else $error("result group out of order");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !take) |=> (in_v_r && $stable(in_item_r)))
    else $error("input register lost a byte");

  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= KIND_ERROR))
    else $error("result kind out of range");
`endif

endmodule
